@@ hdl/cal_pkg.sv @@
// Shared types, codes and sizes for the cursor array list.
`default_nettype none
package cal_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int GRP      = 8;
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

  typedef logic signed [31:0] word_t;

  localparam logic [3:0] CMD_FIRST      = 4'd0;
  localparam logic [3:0] CMD_LAST       = 4'd1;
  localparam logic [3:0] CMD_BACK       = 4'd2;
  localparam logic [3:0] CMD_FORWARD    = 4'd3;
  localparam logic [3:0] CMD_DELETE     = 4'd4;
  localparam logic [3:0] CMD_INS_BEFORE = 4'd5;
  localparam logic [3:0] CMD_INS_AFTER  = 4'd6;
  localparam logic [3:0] CMD_READ_IDX   = 4'd7;
  localparam logic [3:0] CMD_WRITE_IDX  = 4'd8;
  localparam logic [3:0] CMD_WRITE_CUR  = 4'd9;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_BAD_INDEX = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_AT_END    = 3'd4;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_SHUP = 2'd1;
  localparam logic [1:0] OP_SHDN = 2'd2;
  localparam logic [1:0] OP_WR   = 2'd3;

  typedef struct packed {
    logic [3:0]  command;
    word_t       value;
    logic [5:0]  index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    word_t       current_value;
    word_t       read_value;
    logic [6:0]  count;
    logic [5:0]  position;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] at;
    word_t            data;
  } cell_ctl_t;

  typedef struct packed {
    logic             cur_en;
    logic [IDX_W-1:0] cur_at;
    logic             rd_en;
    logic [IDX_W-1:0] rd_at;
  } rsel_t;

endpackage
`default_nettype wire

@@ hdl/cal_cell.sv @@
// One list cell: holds one entry and trades it with its neighbors.
`default_nettype none
module cal_cell import cal_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] cell_idx,
  input  cell_ctl_t        ctl,
  input  word_t            left_q,
  input  word_t            right_q,
  input  rsel_t            rsel,
  output word_t            q,
  output word_t            cur_q,
  output word_t            rd_q
);

  word_t data_r;
  word_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_SHUP: begin
        if (cell_idx > ctl.at) begin
          data_nxt = left_q;
        end else if (cell_idx == ctl.at) begin
          data_nxt = ctl.data;
        end
      end
      OP_SHDN: begin
        if (cell_idx >= ctl.at) begin
          data_nxt = right_q;
        end
      end
      OP_WR: begin
        if (cell_idx == ctl.at) begin
          data_nxt = ctl.data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q     = data_r;
  assign cur_q = (rsel.cur_en && (rsel.cur_at == cell_idx)) ? data_r : '0;
  assign rd_q  = (rsel.rd_en && (rsel.rd_at == cell_idx)) ? data_r : '0;

endmodule
`default_nettype wire

@@ hdl/cal_tree.sv @@
// Registered OR tree that gathers the one selected cell word.
`default_nettype none
module cal_tree import cal_pkg::*; (
  input  logic  clk,
  input  word_t leaf [CAPACITY],
  output word_t sum
);

  word_t grp_r   [NGRP];
  word_t grp_nxt [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | leaf[g * GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  always_comb begin
    sum = '0;
    for (int g = 0; g < NGRP; g++) begin
      sum = sum | grp_r[g];
    end
  end

endmodule
`default_nettype wire

@@ hdl/cursor_array_list.sv @@
// Top level of the cursor array list: command decode, cell row and result register.
//
//  channel | ports                         | payload
//  --------+-------------------------------+-------------------------------------------
//  input   | in_valid, in_ready, in_item   | command, value, index
//  output  | out_valid, out_ready, out_item | status, current_value, read_value, count,
//          |                               | position
//
// Each transaction runs in order: the cells update at acceptance, the
// OR tree captures the selected words, then the result register loads.
// The registered OR tree over the cell row gives the gather step.
// Synchronous active-low reset clears length, cursor and handshake state.
// A waiting result holds in the output register; a new transaction is taken
// once none is in flight and that register is free or is being emptied.
`default_nettype none
module cursor_array_list import cal_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_GATHER = 2'd1;
  localparam logic [1:0] PH_MERGE  = 2'd2;

  logic [1:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] length_r, length_nxt;
  logic [IDX_W-1:0] cursor_r, cursor_nxt;
  logic [2:0]       status_r, status_nxt;
  logic [IDX_W-1:0] idx_r;
  logic             rd_en_r, rd_en_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r;
  logic             accept;
  logic             empty;
  logic             full;
  logic [1:0]       op;
  logic [IDX_W-1:0] op_at;
  cell_ctl_t        ctl;
  rsel_t            rsel;
  word_t            cell_q  [CAPACITY];
  word_t            cell_cq [CAPACITY];
  word_t            cell_rq [CAPACITY];
  word_t            cur_sum;
  word_t            rd_sum;

  assign in_ready = (phase_r == PH_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign empty    = (length_r == '0);
  assign full     = (length_r >= CNT_W'(CAPACITY));

  always_comb begin
    status_nxt = ST_OK;
    length_nxt = length_r;
    cursor_nxt = cursor_r;
    rd_en_nxt  = 1'b0;
    op         = OP_HOLD;
    op_at      = cursor_r;
    case (in_item.command)
      CMD_FIRST: begin
        if (empty) status_nxt = ST_EMPTY;
        else cursor_nxt = '0;
      end
      CMD_LAST: begin
        if (empty) status_nxt = ST_EMPTY;
        else cursor_nxt = IDX_W'(length_r - 1'b1);
      end
      CMD_BACK: begin
        if (empty) status_nxt = ST_EMPTY;
        else if (cursor_r != '0) cursor_nxt = cursor_r - 1'b1;
        else status_nxt = ST_AT_END;
      end
      CMD_FORWARD: begin
        if (empty) status_nxt = ST_EMPTY;
        else if (CNT_W'(cursor_r) + 1'b1 < length_r) cursor_nxt = cursor_r + 1'b1;
        else status_nxt = ST_AT_END;
      end
      CMD_DELETE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          op         = OP_SHDN;
          op_at      = cursor_r;
          length_nxt = length_r - 1'b1;
          if ((length_r - 1'b1 == CNT_W'(cursor_r)) && (cursor_r != '0)) begin
            cursor_nxt = cursor_r - 1'b1;
          end
        end
      end
      CMD_INS_BEFORE: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          op         = OP_SHUP;
          op_at      = cursor_r;
          length_nxt = length_r + 1'b1;
          if (!empty) cursor_nxt = cursor_r + 1'b1;
        end
      end
      CMD_INS_AFTER: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          op         = OP_SHUP;
          length_nxt = length_r + 1'b1;
          if (empty) begin
            op_at      = '0;
            cursor_nxt = '0;
          end else begin
            op_at = cursor_r + 1'b1;
          end
        end
      end
      CMD_READ_IDX: begin
        if (CNT_W'(in_item.index) >= length_r) status_nxt = ST_BAD_INDEX;
        else rd_en_nxt = 1'b1;
      end
      CMD_WRITE_IDX: begin
        if (CNT_W'(in_item.index) >= length_r) begin
          status_nxt = ST_BAD_INDEX;
        end else begin
          op    = OP_WR;
          op_at = in_item.index;
        end
      end
      CMD_WRITE_CUR: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          op    = OP_WR;
          op_at = cursor_r;
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  assign ctl.op   = accept ? op : OP_HOLD;
  assign ctl.at   = op_at;
  assign ctl.data = in_item.value;

  assign rsel.cur_en = !empty;
  assign rsel.cur_at = cursor_r;
  assign rsel.rd_en  = rd_en_r;
  assign rsel.rd_at  = idx_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_q;
    word_t right_q;
    if (i == 0) begin : g_lo
      assign left_q = '0;
    end else begin : g_lo
      assign left_q = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign right_q = '0;
    end else begin : g_hi
      assign right_q = cell_q[i+1];
    end
    cal_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(i)),
      .ctl      (ctl),
      .left_q   (left_q),
      .right_q  (right_q),
      .rsel     (rsel),
      .q        (cell_q[i]),
      .cur_q    (cell_cq[i]),
      .rd_q     (cell_rq[i])
    );
  end

  cal_tree u_cur_tree (
    .clk  (clk),
    .leaf (cell_cq),
    .sum  (cur_sum)
  );

  cal_tree u_rd_tree (
    .clk  (clk),
    .leaf (cell_rq),
    .sum  (rd_sum)
  );

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE:   if (accept) phase_nxt = PH_GATHER;
      PH_GATHER: phase_nxt = PH_MERGE;
      PH_MERGE:  phase_nxt = PH_IDLE;
      default:   phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (phase_r == PH_MERGE) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      length_r    <= '0;
      cursor_r    <= '0;
      rd_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        length_r <= length_nxt;
        cursor_r <= cursor_nxt;
        rd_en_r  <= rd_en_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      idx_r    <= in_item.index;
    end
    if (phase_r == PH_MERGE) begin
      out_item_r.status        <= status_r;
      out_item_r.current_value <= cur_sum;
      out_item_r.read_value    <= rd_sum;
      out_item_r.count         <= length_r;
      out_item_r.position      <= cursor_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= CNT_W'(CAPACITY))
    else $error("length beyond capacity");

  a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (length_r != '0) |-> (CNT_W'(cursor_r) < length_r))
    else $error("cursor outside list");

  a_result_after_merge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(phase_r == PH_MERGE))
    else $error("result raised outside merge");

  a_accept_gathers: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (phase_r == PH_GATHER))
    else $error("accepted transaction not gathered");

  a_slot_free_at_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_MERGE) |-> (!out_valid_r || out_ready))
    else $error("result register busy at merge");
`endif

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the cursor array list: directed and random commands.
`timescale 1ns / 100ps
`default_nettype none
module tb import cal_pkg::*; ();

  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam word_t WORD_MAX = 32'sh7fff_ffff;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  word_t     list_words [CAPACITY];
  int        list_len = 0;
  int        cur_pos = 0;
  out_item_t pending_results [$];

  int errors = 0;
  int results_checked = 0;
  int commands_sent = 0;
  int status_seen [8];
  int cycles = 0;

  bit no_gaps = 1'b0;
  int burst_left = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_phase = 0;

  cursor_array_list dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic out_item_t apply_command(in_item_t it);
    out_item_t res;
    logic [2:0] st;
    word_t rd;
    int i;
    st = ST_OK;
    rd = '0;
    case (it.command)
      CMD_FIRST: begin
        if (list_len == 0) st = ST_EMPTY;
        else cur_pos = 0;
      end
      CMD_LAST: begin
        if (list_len == 0) st = ST_EMPTY;
        else cur_pos = list_len - 1;
      end
      CMD_BACK: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (cur_pos != 0) cur_pos--;
        else st = ST_AT_END;
      end
      CMD_FORWARD: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (cur_pos + 1 < list_len) cur_pos++;
        else st = ST_AT_END;
      end
      CMD_DELETE: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else begin
          for (i = cur_pos; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
          list_len--;
          if (list_len == cur_pos && cur_pos != 0) cur_pos--;
        end
      end
      CMD_INS_BEFORE: begin
        if (list_len >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          for (i = list_len; i > cur_pos; i--) list_words[i] = list_words[i - 1];
          list_words[cur_pos] = it.value;
          list_len++;
          if (list_len != 1) cur_pos++;
        end
      end
      CMD_INS_AFTER: begin
        if (list_len >= CAPACITY) begin
          st = ST_FULL;
        end else if (list_len == 0) begin
          cur_pos = 0;
          list_words[0] = it.value;
          list_len++;
        end else begin
          for (i = list_len; i > cur_pos + 1; i--) list_words[i] = list_words[i - 1];
          list_words[cur_pos + 1] = it.value;
          list_len++;
        end
      end
      CMD_READ_IDX: begin
        if (int'(it.index) >= list_len) st = ST_BAD_INDEX;
        else rd = list_words[it.index];
      end
      CMD_WRITE_IDX: begin
        if (int'(it.index) >= list_len) st = ST_BAD_INDEX;
        else list_words[it.index] = it.value;
      end
      CMD_WRITE_CUR: begin
        if (list_len == 0) st = ST_EMPTY;
        else list_words[cur_pos] = it.value;
      end
      default: ;
    endcase
    status_seen[st]++;
    res.status = st;
    res.current_value = (list_len != 0) ? list_words[cur_pos] : '0;
    res.read_value = rd;
    res.count = 7'(list_len);
    res.position = 6'(cur_pos);
    return res;
  endfunction

  function automatic in_item_t mk_item(logic [3:0] cmd, word_t val, logic [5:0] idx);
    in_item_t it;
    it.command = cmd;
    it.value = val;
    it.index = idx;
    return it;
  endfunction

  function automatic in_item_t random_command(int ins_pct, int del_pct);
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      it.command = $urandom_range(0, 1) ? CMD_INS_BEFORE : CMD_INS_AFTER;
    end else if (r < ins_pct + del_pct) begin
      it.command = CMD_DELETE;
    end else if (r < 97) begin
      case ($urandom_range(0, 6))
        0: it.command = CMD_FIRST;
        1: it.command = CMD_LAST;
        2: it.command = CMD_BACK;
        3: it.command = CMD_FORWARD;
        4: it.command = CMD_READ_IDX;
        5: it.command = CMD_WRITE_IDX;
        default: it.command = CMD_WRITE_CUR;
      endcase
    end else begin
      it.command = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    end
    if (list_len > 0 && $urandom_range(0, 3) != 0) it.index = 6'($urandom_range(0, list_len - 1));
    else it.index = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 9))
      0: it.value = WORD_MIN;
      1: it.value = WORD_MAX;
      2: it.value = word_t'($urandom_range(0, 3)) - 2;
      default: it.value = word_t'($urandom);
    endcase
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_command(it));
    commands_sent++;
    gap = 0;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(0, 12);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 5);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t exp_r;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none actual %0h", $time, got);
    end else begin
      exp_r = pending_results.pop_front();
      results_checked++;
      report_field("status", 32'(exp_r.status), 32'(got.status));
      report_field("current_value", exp_r.current_value, got.current_value);
      report_field("read_value", exp_r.read_value, got.read_value);
      report_field("count", 32'(exp_r.count), 32'(got.count));
      report_field("position", 32'(exp_r.position), 32'(got.position));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_item);
    if (holds_served != hold_requests) begin
      hold_left = LONG_HOLD;
      holds_served++;
    end
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(32, 200);
    end else begin
      rx_mode_left--;
    end
    rx_phase++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ((rx_phase % 7) < 5);
        default: out_ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic test_empty_list();
    send_item(mk_item(CMD_FIRST, WORD_MAX, 6'd0));
    send_item(mk_item(CMD_LAST, WORD_MIN, 6'd63));
    send_item(mk_item(CMD_BACK, '0, 6'd0));
    send_item(mk_item(CMD_FORWARD, '0, 6'd0));
    send_item(mk_item(CMD_DELETE, '0, 6'd0));
    send_item(mk_item(CMD_WRITE_CUR, WORD_MAX, 6'd0));
    send_item(mk_item(CMD_READ_IDX, '0, 6'd0));
    send_item(mk_item(CMD_WRITE_IDX, WORD_MIN, 6'd63));
    send_item(mk_item(CMD_UNUSED_HI, -1, 6'd63));
    wait_drained();
  endtask

  task automatic test_directed_edits();
    send_item(mk_item(CMD_INS_AFTER, WORD_MAX, 6'd0));
    send_item(mk_item(CMD_INS_BEFORE, WORD_MIN, 6'd0));
    send_item(mk_item(CMD_FORWARD, '0, 6'd0));
    send_item(mk_item(CMD_FIRST, '0, 6'd0));
    send_item(mk_item(CMD_BACK, '0, 6'd0));
    send_item(mk_item(CMD_INS_AFTER, '0, 6'd0));
    send_item(mk_item(CMD_LAST, '0, 6'd0));
    send_item(mk_item(CMD_WRITE_CUR, -1, 6'd0));
    send_item(mk_item(CMD_READ_IDX, '0, 6'd2));
    send_item(mk_item(CMD_READ_IDX, '0, 6'd3));
    send_item(mk_item(CMD_WRITE_IDX, 32'sh5555_5555, 6'd1));
    send_item(mk_item(CMD_WRITE_IDX, 32'sh2aaa_aaaa, 6'd63));
    send_item(mk_item(CMD_READ_IDX, '0, 6'd1));
    send_item(mk_item(CMD_DELETE, '0, 6'd0));
    send_item(mk_item(CMD_FIRST, '0, 6'd0));
    send_item(mk_item(CMD_DELETE, '0, 6'd0));
    send_item(mk_item(CMD_DELETE, '0, 6'd0));
    send_item(mk_item(CMD_INS_BEFORE, 32'shaaaa_aaaa, 6'd0));
    send_item(mk_item(CMD_DELETE, '0, 6'd0));
    wait_drained();
  endtask

  task automatic test_random_mix(int n, int ins_pct, int del_pct, bit steady);
    no_gaps = steady;
    repeat (n) send_item(random_command(ins_pct, del_pct));
    no_gaps = 1'b0;
    wait_drained();
  endtask

  task automatic test_fill_and_drain();
    in_item_t it;
    no_gaps = 1'b1;
    while (list_len < CAPACITY) begin
      if ($urandom_range(0, 4) == 0) it = random_command(0, 0);
      else it = random_command(100, 0);
      send_item(it);
    end
    no_gaps = 1'b0;
    repeat (3) send_item(random_command(100, 0));
    send_item(mk_item(CMD_READ_IDX, '0, 6'd63));
    send_item(mk_item(CMD_WRITE_IDX, WORD_MIN, 6'd63));
    send_item(mk_item(CMD_LAST, '0, 6'd0));
    repeat (40) send_item(random_command(10, 0));
    while (list_len > 0) begin
      if ($urandom_range(0, 3) == 0) it = random_command(0, 0);
      else it = mk_item(CMD_DELETE, word_t'($urandom), 6'($urandom_range(0, 63)));
      send_item(it);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_requests++;
    no_gaps = 1'b1;
    repeat (40) send_item(random_command(30, 20));
    no_gaps = 1'b0;
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < CAPACITY; i++) list_words[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_directed_edits();
    test_random_mix(250, 30, 20, 1'b0);
    test_fill_and_drain();
    test_backpressure();
    test_random_mix(150, 20, 28, 1'b1);
    test_random_mix(280, 26, 24, 1'b0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d commands, %0d results compared field by field.",
             commands_sent, results_checked);
    $display("Status mix: ok %0d, empty %0d, bad index %0d, full %0d, end stop %0d.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BAD_INDEX],
             status_seen[ST_FULL], status_seen[ST_AT_END]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
